FILE: rtl/core/bcps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bcps_pkg;

   // Capacity of the point store and width of one stored coordinate.
   localparam int MAX_POINTS  = 1024;
   localparam int COORD_WIDTH = 16;

   // Fixed widths of the channel fields.
   localparam int FIELD_W = 16;
   localparam int INDEX_W = 16;
   localparam int SCORE_W = 48;

   // Derived widths.
   localparam int ADDR_W    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int COUNT_W   = $clog2(MAX_POINTS + 1);
   localparam int DIFF_W    = COORD_WIDTH + 1;
   localparam int SQ_W      = 2 * COORD_WIDTH;
   localparam int SQ3_W     = SQ_W + 2;
   localparam int ACC_SUM_W = ((SQ3_W > SCORE_W) ? SQ3_W : SCORE_W) + 1;
   localparam int EXT_W     = 40;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [SCORE_W-1:0]            score_type;
   typedef logic [INDEX_W-1:0]            index_type;
   typedef logic [COUNT_W-1:0]            count_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } point_type;

   localparam score_type SCORE_MAX = '1;

   // Control into the distance unit.
   typedef struct packed {
      logic clear;
      logic valid;
   } dist_ctrl_type;

   // Status back from the distance unit.
   typedef struct packed {
      logic busy;
   } dist_stat_type;

   // Take the low COORD_WIDTH bits of an input field as a signed coordinate.
   function automatic coord_type to_coord(input logic [FIELD_W-1:0] raw);
      logic [EXT_W-1:0] w;
      w = {{(EXT_W - FIELD_W){1'b0}}, raw};
      return w[COORD_WIDTH-1:0];
   endfunction

   // Sign-extend a coordinate and keep the low FIELD_W bits for output.
   function automatic logic [FIELD_W-1:0] to_field(input coord_type c);
      logic [EXT_W-1:0] w;
      w = {{(EXT_W - COORD_WIDTH){c[COORD_WIDTH-1]}}, c};
      return w[FIELD_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bcps_dist_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module bcps_dist_unit (
   input  wire                      clock,
   input  wire                      reset,
   input  wire bcps_pkg::dist_ctrl_type  ctrl,
   input  wire bcps_pkg::point_type      cand_point,
   input  wire bcps_pkg::point_type      store_point,
   output bcps_pkg::dist_stat_type  stat,
   output bcps_pkg::score_type      acc
);
   import bcps_pkg::*;

   logic [DIFF_W-1:0]      dx, dy, dz;
   logic [COORD_WIDTH-1:0] ax_in, ay_in, az_in;
   logic [COORD_WIDTH-1:0] ax_ff, ay_ff, az_ff;
   logic [SQ_W-1:0]        sqx_in, sqy_in, sqz_in;
   logic [SQ_W-1:0]        sqx_ff, sqy_ff, sqz_ff;
   logic [SQ3_W-1:0]       sum3_in, sum3_ff;
   logic [ACC_SUM_W-1:0]   acc_sum;
   score_type              acc_in, acc_ff;
   logic                   s1_valid_ff, s2_valid_ff, s3_valid_ff;

   // Stage 1: absolute coordinate differences.
   always_comb begin
      dx = {cand_point.x[COORD_WIDTH-1], cand_point.x}
         - {store_point.x[COORD_WIDTH-1], store_point.x};
      dy = {cand_point.y[COORD_WIDTH-1], cand_point.y}
         - {store_point.y[COORD_WIDTH-1], store_point.y};
      dz = {cand_point.z[COORD_WIDTH-1], cand_point.z}
         - {store_point.z[COORD_WIDTH-1], store_point.z};
      ax_in = dx[DIFF_W-1] ? COORD_WIDTH'(-dx) : dx[COORD_WIDTH-1:0];
      ay_in = dy[DIFF_W-1] ? COORD_WIDTH'(-dy) : dy[COORD_WIDTH-1:0];
      az_in = dz[DIFF_W-1] ? COORD_WIDTH'(-dz) : dz[COORD_WIDTH-1:0];
   end

   // Stage 2: squares of the differences.
   assign sqx_in = SQ_W'(ax_ff) * SQ_W'(ax_ff);
   assign sqy_in = SQ_W'(ay_ff) * SQ_W'(ay_ff);
   assign sqz_in = SQ_W'(az_ff) * SQ_W'(az_ff);

   // Stage 3: squared distance of one point.
   assign sum3_in = SQ3_W'(sqx_ff) + SQ3_W'(sqy_ff) + SQ3_W'(sqz_ff);

   // Stage 4: saturating accumulation of the score.
   always_comb begin
      acc_sum = ACC_SUM_W'(acc_ff) + ACC_SUM_W'(sum3_ff);
      if (acc_sum > ACC_SUM_W'(SCORE_MAX)) begin
         acc_in = SCORE_MAX;
      end else begin
         acc_in = acc_sum[SCORE_W-1:0];
      end
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= ctrl.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      az_ff   <= az_in;
      sqx_ff  <= sqx_in;
      sqy_ff  <= sqy_in;
      sqz_ff  <= sqz_in;
      sum3_ff <= sum3_in;
   end

   // Accumulator, zeroed at the start of each candidate.
   always_ff @(posedge clock) begin
      if (reset || ctrl.clear) begin
         acc_ff <= '0;
      end else if (s3_valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign stat.busy = s1_valid_ff | s2_valid_ff | s3_valid_ff;
   assign acc       = acc_ff;

endmodule

`default_nettype wire

FILE: rtl/core/best_candidate_point_selector.sv
`timescale 1ns / 1ps
`default_nettype none

// Best candidate point selector.
// The req channel carries beats of two kinds. A beat with req_mode low loads
// one cloud point into the point store and leaves the block ready, so loads
// can follow back to back; once the store is full, further points are dropped
// and the overflow flag is raised. A beat with req_mode high is a candidate:
// the block walks every stored point, one point per cycle through a
// four-stage distance unit, and sums the squared distances. A candidate holds
// req_stall high while the single read port of the point store is walked and
// the pipeline drains, so a new beat is taken only once the last candidate
// is scored. The lowest score wins, ties keep the earlier candidate. A
// candidate with req_last_candidate high ends the job: once it is scored,
// rsp_valid rises, carrying the best point, its index, its score and the
// overflow flag, and the job state clears. The rsp beat sits in an output
// register; loads and candidates are still taken while it waits, and only the
// next end of job holds, with req_stall high, until rsp_stall lets the old
// beat go. Reset empties the cloud and drops any pending beat.

module best_candidate_point_selector (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_stall,
   input  wire                                  req_mode,
   input  wire  signed [bcps_pkg::FIELD_W-1:0]  req_x_coord,
   input  wire  signed [bcps_pkg::FIELD_W-1:0]  req_y_coord,
   input  wire  signed [bcps_pkg::FIELD_W-1:0]  req_z_coord,
   input  wire                                  req_last_candidate,
   output logic                                 rsp_valid,
   input  wire                                  rsp_stall,
   output logic signed [bcps_pkg::FIELD_W-1:0]  rsp_best_x,
   output logic signed [bcps_pkg::FIELD_W-1:0]  rsp_best_y,
   output logic signed [bcps_pkg::FIELD_W-1:0]  rsp_best_z,
   output logic        [bcps_pkg::INDEX_W-1:0]  rsp_best_index,
   output logic        [bcps_pkg::SCORE_W-1:0]  rsp_top_score,
   output logic                                 rsp_cloud_overflow
);
   import bcps_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCORE  = 3'd1;
   localparam logic [2:0] ST_DRAIN  = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;

   logic [2:0]    state_ff, state_in;
   count_type     point_count_ff, point_count_in;
   count_type     iss_cnt_ff, iss_cnt_in;
   logic          overflow_ff, overflow_in;
   logic          have_best_ff, have_best_in;
   score_type     top_score_ff, top_score_in;
   point_type     best_point_ff, best_point_in;
   index_type     best_index_ff, best_index_in;
   index_type     cand_count_ff, cand_count_in;
   point_type     cand_ff, cand_in;
   logic          last_ff, last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_load;

   logic          req_take, rsp_take;
   point_type     req_point;

   point_type     point_mem [MAX_POINTS];
   logic          wr_en;
   logic          rd_en;
   point_type     rd_data_ff;
   logic          rd_valid_ff;

   dist_ctrl_type dist_ctrl;
   dist_ctrl_type dist_ctrl_mux;
   dist_stat_type dist_stat;
   score_type     dist_acc;

   logic [FIELD_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   index_type          rsp_index_ff;
   score_type          rsp_score_ff;
   logic               rsp_overflow_ff;

   // Handshake decode.
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   assign req_point.x = to_coord(req_x_coord);
   assign req_point.y = to_coord(req_y_coord);
   assign req_point.z = to_coord(req_z_coord);

   // Sequencer and job state.
   always_comb begin
      state_in       = state_ff;
      point_count_in = point_count_ff;
      iss_cnt_in     = iss_cnt_ff;
      overflow_in    = overflow_ff;
      have_best_in   = have_best_ff;
      top_score_in   = top_score_ff;
      best_point_in  = best_point_ff;
      best_index_in  = best_index_ff;
      cand_count_in  = cand_count_ff;
      cand_in        = cand_ff;
      last_in        = last_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      rsp_load       = 1'b0;
      dist_ctrl      = '0;
      rsp_valid_in   = rsp_valid_ff && !rsp_take;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (!req_mode) begin
                  if (point_count_ff < count_type'(MAX_POINTS)) begin
                     wr_en          = 1'b1;
                     point_count_in = point_count_ff + count_type'(1);
                  end else begin
                     overflow_in = 1'b1;
                  end
               end else begin
                  cand_in         = req_point;
                  last_in         = req_last_candidate;
                  iss_cnt_in      = '0;
                  dist_ctrl.clear = 1'b1;
                  state_in = (point_count_ff == '0) ? ST_DRAIN : ST_SCORE;
               end
            end
         end
         ST_SCORE: begin
            // Issue one store read per cycle.
            rd_en      = 1'b1;
            iss_cnt_in = iss_cnt_ff + count_type'(1);
            if (iss_cnt_in == point_count_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_valid_ff && !dist_stat.busy) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // Strictly lower score replaces the best so far.
            if (!have_best_ff || (dist_acc < top_score_ff)) begin
               have_best_in  = 1'b1;
               top_score_in  = dist_acc;
               best_point_in = cand_ff;
               best_index_in = cand_count_ff;
            end
            cand_count_in = cand_count_ff + index_type'(1);
            state_in      = last_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            // Wait for the output register, then publish and clear the job.
            if (!rsp_valid_ff || rsp_take) begin
               rsp_load       = 1'b1;
               rsp_valid_in   = 1'b1;
               point_count_in = '0;
               overflow_in    = 1'b0;
               have_best_in   = 1'b0;
               top_score_in   = '0;
               best_point_in  = '0;
               best_index_in  = '0;
               cand_count_in  = '0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         point_count_ff <= '0;
         iss_cnt_ff     <= '0;
         overflow_ff    <= 1'b0;
         have_best_ff   <= 1'b0;
         top_score_ff   <= '0;
         best_point_ff  <= '0;
         best_index_ff  <= '0;
         cand_count_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
         rd_valid_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         point_count_ff <= point_count_in;
         iss_cnt_ff     <= iss_cnt_in;
         overflow_ff    <= overflow_in;
         have_best_ff   <= have_best_in;
         top_score_ff   <= top_score_in;
         best_point_ff  <= best_point_in;
         best_index_ff  <= best_index_in;
         cand_count_ff  <= cand_count_in;
         rsp_valid_ff   <= rsp_valid_in;
         rd_valid_ff    <= rd_en;
      end
   end

   // Candidate holding registers.
   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
      last_ff <= last_in;
   end

   // Point store write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         point_mem[point_count_ff[ADDR_W-1:0]] <= req_point;
      end
   end

   // Point store registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= point_mem[iss_cnt_ff[ADDR_W-1:0]];
      end
   end

   // Feed the unit with each returned read.
   always_comb begin
      dist_ctrl_mux       = dist_ctrl;
      dist_ctrl_mux.valid = rd_valid_ff;
   end

   // Distance accumulator.
   bcps_dist_unit u_dist (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (dist_ctrl_mux),
      .cand_point  (cand_ff),
      .store_point (rd_data_ff),
      .stat        (dist_stat),
      .acc         (dist_acc)
   );

   // Result output register.
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_x_ff        <= to_field(best_point_ff.x);
         rsp_y_ff        <= to_field(best_point_ff.y);
         rsp_z_ff        <= to_field(best_point_ff.z);
         rsp_index_ff    <= best_index_ff;
         rsp_score_ff    <= top_score_ff;
         rsp_overflow_ff <= overflow_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_best_x         = rsp_x_ff;
   assign rsp_best_y         = rsp_y_ff;
   assign rsp_best_z         = rsp_z_ff;
   assign rsp_best_index     = rsp_index_ff;
   assign rsp_top_score      = rsp_score_ff;
   assign rsp_cloud_overflow = rsp_overflow_ff;

endmodule

`default_nettype wire
